[src/twet_pkg.sv]
// shared types and codes for the time window entry table
// no dependencies
package twet_pkg;

   // action codes
   localparam logic [2:0] ACT_ADD    = 3'd0;
   localparam logic [2:0] ACT_REMOVE = 3'd1;
   localparam logic [2:0] ACT_GET    = 3'd2;
   localparam logic [2:0] ACT_WINDOW = 3'd3;
   localparam logic [2:0] ACT_SPAN   = 3'd4;

   // status codes
   localparam logic [2:0] STS_OK      = 3'd0;
   localparam logic [2:0] STS_DUP     = 3'd1;
   localparam logic [2:0] STS_ORDER   = 3'd2;
   localparam logic [2:0] STS_MISSING = 3'd3;
   localparam logic [2:0] STS_FULL    = 3'd4;
   localparam logic [2:0] STS_EMPTY   = 3'd5;

   localparam int TimeW   = 64;
   localparam int StampW  = 32;
   localparam int PortIdW = 16;
   localparam int ReqW    = 152;
   localparam int RspW    = 152;

   typedef logic signed [TimeW-1:0] time_type;
   typedef logic [StampW-1:0] stamp_type;

endpackage

[src/twet_ram.sv]
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module twet_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

[src/time_window_entry_table.sv]
// Time window entry table: add, remove, get, ordered window query and span query.
// Add, remove, get and span: one sweep over the single ram read port, then decide, then send
// the result; the next request is taken only after the last result transfer of the item.
// Window query with n matches: one sweep per ordered result (at least one sweep), plus an
// overhang sweep when both bounds are soft; rsp stalls hold the send state and add on top.
// Reset (synchronous, active high) clears all valid marks and the stamp counter; no clearing pass.
// depends on twet_pkg and twet_ram
module time_window_entry_table
   import twet_pkg::*;
#(
   parameter int TABLE_DEPTH = 32,
   parameter int ID_BITS     = 16
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   output logic            req_tready,
   // action[2:0], entry_id[18:3], window_start[82:19], window_end[146:83],
   // soft_lower[147], soft_upper[148], zero fill
   input  logic [ReqW-1:0] req_tdata,
   output logic            rsp_tvalid,
   input  logic            rsp_tready,
   // status[2:0], match_valid[3], match_id[19:4], match_start[83:20],
   // match_end[147:84], zero fill
   output logic [RspW-1:0] rsp_tdata,
   output logic            rsp_tlast
);

   localparam int IdW   = (ID_BITS < PortIdW) ? ID_BITS : PortIdW;
   localparam int IdxW  = $clog2(TABLE_DEPTH);
   localparam int CntW  = $clog2(TABLE_DEPTH + 1);
   localparam int SlotW = IdW + 2 * TimeW + StampW;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_DECIDE = 2'd2;
   localparam logic [1:0] ST_SEND   = 2'd3;

   logic [1:0] state_ff, state_in;

   // latched command
   logic [2:0]     act_ff;
   logic [IdW-1:0] id_ff;
   time_type       ws_ff, we_ff;
   logic           sl_ff, su_ff;

   // scan control
   logic [CntW-1:0] scan_cnt_ff, scan_cnt_in;
   logic            proc_v_ff;
   logic [IdxW-1:0] proc_idx_ff;

   // table state
   logic [TABLE_DEPTH-1:0] valid_ff, valid_in;
   logic [TABLE_DEPTH-1:0] emitted_ff, emitted_in;
   stamp_type              stamp_ff, stamp_in;

   // scan results
   logic            found_ff, found_in;
   logic [IdxW-1:0] found_idx_ff, found_idx_in;
   logic [IdW-1:0]  got_id_ff, got_id_in;
   time_type        got_st_ff, got_st_in, got_en_ff, got_en_in;
   logic            any_ff, any_in;
   time_type        lo_ff, lo_in, hi_ff, hi_in;
   logic            best_v_ff, best_v_in;
   logic [IdxW-1:0] best_idx_ff, best_idx_in;
   time_type        best_key_ff, best_key_in;
   stamp_type       best_stamp_ff, best_stamp_in;
   logic [IdW-1:0]  best_id_ff, best_id_in;
   time_type        best_st_ff, best_st_in, best_en_ff, best_en_in;
   logic [CntW-1:0] count_ff, count_in, sent_ff, sent_in, sent_inc;
   logic            count_en_ff, count_en_in;
   logic            phase_ff, phase_in;

   // response register
   logic           rsp_v_ff, rsp_v_in;
   logic [2:0]     rsp_sts_ff, rsp_sts_in;
   logic           rsp_mv_ff, rsp_mv_in;
   logic [IdW-1:0] rsp_id_ff, rsp_id_in;
   time_type       rsp_st_ff, rsp_st_in, rsp_en_ff, rsp_en_in;
   logic           rsp_last_ff, rsp_last_in;

   // ram ports
   logic             wr_en;
   logic [IdxW-1:0]  wr_addr;
   logic [SlotW-1:0] wr_data, rd_data;
   logic             rd_en;

   // decoded slot read
   logic [IdW-1:0] e_id;
   time_type       e_st, e_en, e_key, e_v;
   stamp_type      e_stamp;
   logic           e_live, win_ok, is_query, q_h, q_a, q_b, q_any, cand, better;

   // free slot search
   logic            free_v;
   logic [IdxW-1:0] free_idx;
   logic            full;

   twet_ram #(.WIDTH(SlotW), .DEPTH(TABLE_DEPTH)) u_slots (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (scan_cnt_ff[IdxW-1:0]),
      .rd_data (rd_data)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {4'b0, rsp_en_ff, rsp_st_ff, PortIdW'(rsp_id_ff), rsp_mv_ff, rsp_sts_ff};

   assign rd_en   = (state_ff == ST_SCAN) && (scan_cnt_ff < CntW'(TABLE_DEPTH));
   assign wr_addr = free_idx;
   assign wr_data = {stamp_ff, we_ff, ws_ff, id_ff};

   // slot fields and match qualifiers
   assign e_id    = rd_data[IdW-1:0];
   assign e_st    = rd_data[IdW +: TimeW];
   assign e_en    = rd_data[IdW+TimeW +: TimeW];
   assign e_stamp = rd_data[IdW+2*TimeW +: StampW];
   assign e_live  = proc_v_ff && valid_ff[proc_idx_ff] && !emitted_ff[proc_idx_ff];
   assign win_ok  = (ws_ff <= we_ff);
   assign is_query = (act_ff == ACT_WINDOW) && win_ok && e_live;
   assign q_h = is_query && !sl_ff && (e_st >= ws_ff) && (e_st <= we_ff)
                && (su_ff || (e_en <= we_ff));
   assign q_a = is_query && sl_ff && (e_en >= ws_ff) && (e_en <= we_ff);
   assign q_b = is_query && sl_ff && su_ff && (e_st <= we_ff) && (e_en > we_ff);
   assign q_any = q_h || q_a || q_b;
   assign cand  = phase_ff ? q_b : (q_h || q_a);
   assign e_key = (phase_ff || !sl_ff) ? e_st : e_en;
   assign better = !best_v_ff || (e_key < best_key_ff)
                   || ((e_key == best_key_ff) && (e_stamp < best_stamp_ff));
   assign e_v = su_ff ? e_st : e_en;
   assign sent_inc = sent_ff + CntW'(1);
   assign full = &valid_ff;

   // lowest free slot
   always_comb begin
      free_v   = 1'b0;
      free_idx = '0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         if (!free_v && !valid_ff[i]) begin
            free_v   = 1'b1;
            free_idx = IdxW'(i);
         end
      end
   end

   // control and datapath next state
   always_comb begin
      state_in      = state_ff;
      scan_cnt_in   = scan_cnt_ff;
      valid_in      = valid_ff;
      emitted_in    = emitted_ff;
      stamp_in      = stamp_ff;
      found_in      = found_ff;
      found_idx_in  = found_idx_ff;
      got_id_in     = got_id_ff;
      got_st_in     = got_st_ff;
      got_en_in     = got_en_ff;
      any_in        = any_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      best_v_in     = best_v_ff;
      best_idx_in   = best_idx_ff;
      best_key_in   = best_key_ff;
      best_stamp_in = best_stamp_ff;
      best_id_in    = best_id_ff;
      best_st_in    = best_st_ff;
      best_en_in    = best_en_ff;
      count_in      = count_ff;
      sent_in       = sent_ff;
      count_en_in   = count_en_ff;
      phase_in      = phase_ff;
      rsp_v_in      = rsp_v_ff;
      rsp_sts_in    = rsp_sts_ff;
      rsp_mv_in     = rsp_mv_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_st_in     = rsp_st_ff;
      rsp_en_in     = rsp_en_ff;
      rsp_last_in   = rsp_last_ff;
      wr_en         = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in    = ST_SCAN;
               scan_cnt_in = '0;
               emitted_in  = '0;
               found_in    = 1'b0;
               any_in      = 1'b0;
               best_v_in   = 1'b0;
               count_in    = '0;
               sent_in     = '0;
               count_en_in = 1'b1;
               phase_in    = 1'b0;
            end
         end
         ST_SCAN: begin
            if (rd_en) begin
               scan_cnt_in = scan_cnt_ff + CntW'(1);
            end
            // id lookup
            if (proc_v_ff && valid_ff[proc_idx_ff] && (e_id == id_ff)) begin
               found_in     = 1'b1;
               found_idx_in = proc_idx_ff;
               got_id_in    = e_id;
               got_st_in    = e_st;
               got_en_in    = e_en;
            end
            // span extremes
            if (proc_v_ff && valid_ff[proc_idx_ff]) begin
               any_in = 1'b1;
               if (!any_ff || (e_st < lo_ff)) begin
                  lo_in = e_st;
               end
               if (!any_ff || (e_v > hi_ff)) begin
                  hi_in = e_v;
               end
            end
            // match count, first sweep only
            if (count_en_ff && q_any) begin
               count_in = count_ff + CntW'(1);
            end
            // ordered min search
            if (cand && better) begin
               best_v_in     = 1'b1;
               best_idx_in   = proc_idx_ff;
               best_key_in   = e_key;
               best_stamp_in = e_stamp;
               best_id_in    = e_id;
               best_st_in    = e_st;
               best_en_in    = e_en;
            end
            if (proc_v_ff && (proc_idx_ff == IdxW'(TABLE_DEPTH - 1))) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            state_in    = ST_SEND;
            rsp_v_in    = 1'b1;
            rsp_sts_in  = STS_OK;
            rsp_mv_in   = 1'b0;
            rsp_id_in   = '0;
            rsp_st_in   = '0;
            rsp_en_in   = '0;
            rsp_last_in = 1'b1;
            count_en_in = 1'b0;
            unique case (act_ff)
               ACT_ADD: begin
                  priority if (found_ff) begin
                     rsp_sts_in = STS_DUP;
                  end else if (!win_ok) begin
                     rsp_sts_in = STS_ORDER;
                  end else if (full) begin
                     rsp_sts_in = STS_FULL;
                  end else begin
                     wr_en              = free_v;
                     valid_in[free_idx] = 1'b1;
                     stamp_in           = stamp_ff + StampW'(1);
                  end
               end
               ACT_REMOVE: begin
                  if (found_ff) begin
                     valid_in[found_idx_ff] = 1'b0;
                  end else begin
                     rsp_sts_in = STS_MISSING;
                  end
               end
               ACT_GET: begin
                  if (found_ff) begin
                     rsp_mv_in = 1'b1;
                     rsp_id_in = got_id_ff;
                     rsp_st_in = got_st_ff;
                     rsp_en_in = got_en_ff;
                  end else begin
                     rsp_sts_in = STS_MISSING;
                  end
               end
               ACT_WINDOW: begin
                  priority if (best_v_ff) begin
                     rsp_mv_in   = 1'b1;
                     rsp_id_in   = best_id_ff;
                     rsp_st_in   = best_st_ff;
                     rsp_en_in   = best_en_ff;
                     rsp_last_in = (sent_inc == count_ff);
                     emitted_in[best_idx_ff] = 1'b1;
                     sent_in     = sent_inc;
                  end else if (sl_ff && su_ff && !phase_ff && (sent_ff != count_ff)) begin
                     // end-in-window part done, sweep again for the overhang part
                     state_in    = ST_SCAN;
                     rsp_v_in    = 1'b0;
                     phase_in    = 1'b1;
                     scan_cnt_in = '0;
                  end else begin
                     rsp_last_in = 1'b1;
                  end
               end
               ACT_SPAN: begin
                  if (any_ff) begin
                     rsp_mv_in = 1'b1;
                     rsp_st_in = lo_ff;
                     rsp_en_in = hi_ff;
                  end else begin
                     rsp_sts_in = STS_EMPTY;
                  end
               end
               default: begin
               end
            endcase
         end
         ST_SEND: begin
            if (rsp_tready) begin
               rsp_v_in = 1'b0;
               if (rsp_last_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in    = ST_SCAN;
                  scan_cnt_in = '0;
                  best_v_in   = 1'b0;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         valid_ff    <= '0;
         stamp_ff    <= '0;
         rsp_v_ff    <= 1'b0;
         proc_v_ff   <= 1'b0;
         scan_cnt_ff <= '0;
         count_ff    <= '0;
         sent_ff     <= '0;
      end else begin
         state_ff    <= state_in;
         valid_ff    <= valid_in;
         stamp_ff    <= stamp_in;
         rsp_v_ff    <= rsp_v_in;
         proc_v_ff   <= rd_en;
         scan_cnt_ff <= scan_cnt_in;
         count_ff    <= count_in;
         sent_ff     <= sent_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         act_ff <= req_tdata[2:0];
         id_ff  <= req_tdata[3 +: IdW];
         ws_ff  <= req_tdata[82:19];
         we_ff  <= req_tdata[146:83];
         sl_ff  <= req_tdata[147];
         su_ff  <= req_tdata[148];
      end
      proc_idx_ff   <= scan_cnt_ff[IdxW-1:0];
      emitted_ff    <= emitted_in;
      found_ff      <= found_in;
      found_idx_ff  <= found_idx_in;
      got_id_ff     <= got_id_in;
      got_st_ff     <= got_st_in;
      got_en_ff     <= got_en_in;
      any_ff        <= any_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      best_v_ff     <= best_v_in;
      best_idx_ff   <= best_idx_in;
      best_key_ff   <= best_key_in;
      best_stamp_ff <= best_stamp_in;
      best_id_ff    <= best_id_in;
      best_st_ff    <= best_st_in;
      best_en_ff    <= best_en_in;
      count_en_ff   <= count_en_in;
      phase_ff      <= phase_in;
      rsp_sts_ff    <= rsp_sts_in;
      rsp_mv_ff     <= rsp_mv_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_st_ff     <= rsp_st_in;
      rsp_en_ff     <= rsp_en_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // one item in work: no new transfer while a result is pending
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready) else $error("request taken while response pending");

   // results sent never exceed matches counted
   a_sent_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEND) && (act_ff == ACT_WINDOW) |-> (sent_ff <= count_ff))
      else $error("more matches sent than counted");

   // matches counted never exceed live entries
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DECIDE) |-> (count_ff <= CntW'($countones(valid_ff))))
      else $error("match count above live entries");

   // an entry is added only with a stamp advance
   a_stamp_step: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> (stamp_ff == $past(stamp_ff) + StampW'(1)))
      else $error("stamp did not advance on add");

endmodule

[verif/time_window_entry_table_tb.sv]
// testbench for the time window entry table: directed and random add, remove, get,
// window and span transfers checked against a local table predictor
// depends on twet_pkg and the time_window_entry_table rtl
`timescale 1ns / 1ps

module time_window_entry_table_tb
   import twet_pkg::*;
;

   localparam int Depth      = 32;
   localparam int CycleLimit = 3000000;
   localparam int IdlePct    = 22;
   localparam int HoldCycles = 600;

   typedef struct packed {
      logic [2:0]  status;
      logic        valid;
      logic [15:0] id;
      time_type    start;
      time_type    stop;
      logic        last;
   } table_rsp_type;

   logic            clock;
   logic            reset;
   logic            req_tvalid;
   logic            req_tready;
   logic [ReqW-1:0] req_tdata;
   logic            rsp_tvalid;
   logic            rsp_tready;
   logic [RspW-1:0] rsp_tdata;
   logic            rsp_tlast;

   // predictor state
   bit          slot_used [Depth];
   logic [15:0] slot_key [Depth];
   time_type    slot_begin [Depth];
   time_type    slot_finish [Depth];
   stamp_type   slot_order [Depth];
   stamp_type   next_stamp;
   int          sel_idx [Depth];

   table_rsp_type pending_rsp [$];
   int          error_count;
   int          cycle_count = 0;
   int          hold_left = 0;
   int          hold_seq;
   int          hold_seen = 0;
   bit          no_idle;

   time_window_entry_table #(.TABLE_DEPTH(Depth), .ID_BITS(16)) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // timeout watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   function automatic void push_rsp(input logic [2:0] st, input logic v, input logic [15:0] id,
                                    input time_type s, input time_type e, input logic last);
      table_rsp_type r;
      r.status = st;
      r.valid  = v;
      r.id     = id;
      r.start  = s;
      r.stop   = e;
      r.last   = last;
      pending_rsp = {pending_rsp, r};
   endfunction

   function automatic bit precedes(input int a, input int b, input bit by_end);
      time_type ka;
      time_type kb;
      ka = by_end ? slot_finish[a] : slot_begin[a];
      kb = by_end ? slot_finish[b] : slot_begin[b];
      if (ka != kb) return ka < kb;
      return slot_order[a] < slot_order[b];
   endfunction

   // insertion sort of sel_idx[lo .. hi-1]
   function automatic void sort_sel(input int lo, input int hi, input bit by_end);
      int v;
      int j;
      for (int i = lo + 1; i < hi; i++) begin
         v = sel_idx[i];
         j = i - 1;
         while (j >= lo && precedes(v, sel_idx[j], by_end)) begin
            sel_idx[j + 1] = sel_idx[j];
            j--;
         end
         sel_idx[j + 1] = v;
      end
   endfunction

   function automatic int find_key(input logic [15:0] id);
      for (int i = 0; i < Depth; i++)
         if (slot_used[i] && slot_key[i] == id) return i;
      return -1;
   endfunction

   // table predictor: updates state and queues the expected responses
   function automatic void table_predict(input logic [2:0] act, input logic [15:0] id,
                                         input time_type ws, input time_type we,
                                         input bit sl, input bit su);
      int s;
      int n;
      int m;
      bit any;
      time_type lo;
      time_type hi;
      time_type v;
      n = 0;
      m = 0;
      any = 0;
      lo = '0;
      hi = '0;
      case (act)
         ACT_ADD: begin
            s = -1;
            for (int i = Depth - 1; i >= 0; i--)
               if (!slot_used[i]) s = i;
            if (find_key(id) >= 0) push_rsp(STS_DUP, 0, 0, 0, 0, 1);
            else if (ws > we) push_rsp(STS_ORDER, 0, 0, 0, 0, 1);
            else if (s < 0) push_rsp(STS_FULL, 0, 0, 0, 0, 1);
            else begin
               slot_used[s]   = 1;
               slot_key[s]    = id;
               slot_begin[s]  = ws;
               slot_finish[s] = we;
               slot_order[s]  = next_stamp;
               next_stamp     = next_stamp + 1;
               push_rsp(STS_OK, 0, 0, 0, 0, 1);
            end
         end
         ACT_REMOVE, ACT_GET: begin
            s = find_key(id);
            if (s < 0) push_rsp(STS_MISSING, 0, 0, 0, 0, 1);
            else if (act == ACT_REMOVE) begin
               slot_used[s] = 0;
               push_rsp(STS_OK, 0, 0, 0, 0, 1);
            end else begin
               push_rsp(STS_OK, 1, slot_key[s], slot_begin[s], slot_finish[s], 1);
            end
         end
         ACT_WINDOW: begin
            if (ws <= we) begin
               if (!sl) begin
                  for (int i = 0; i < Depth; i++)
                     if (slot_used[i] && slot_begin[i] >= ws && slot_begin[i] <= we &&
                         (su || slot_finish[i] <= we)) begin
                        sel_idx[n] = i;
                        n++;
                     end
                  sort_sel(0, n, 0);
               end else begin
                  for (int i = 0; i < Depth; i++)
                     if (slot_used[i] && slot_finish[i] >= ws && slot_finish[i] <= we) begin
                        sel_idx[n] = i;
                        n++;
                     end
                  sort_sel(0, n, 1);
                  // both soft: entries straddling the window end follow, by start
                  if (su) begin
                     for (int i = 0; i < Depth; i++)
                        if (slot_used[i] && slot_begin[i] <= we && slot_finish[i] > we &&
                            n + m < Depth) begin
                           sel_idx[n + m] = i;
                           m++;
                        end
                     sort_sel(n, n + m, 0);
                     n += m;
                  end
               end
            end
            if (n == 0) push_rsp(STS_OK, 0, 0, 0, 0, 1);
            for (int k = 0; k < n; k++)
               push_rsp(STS_OK, 1, slot_key[sel_idx[k]], slot_begin[sel_idx[k]],
                        slot_finish[sel_idx[k]], k == n - 1);
         end
         ACT_SPAN: begin
            for (int i = 0; i < Depth; i++) begin
               if (slot_used[i]) begin
                  v = su ? slot_begin[i] : slot_finish[i];
                  if (!any) begin
                     lo = slot_begin[i];
                     hi = v;
                     any = 1;
                  end else begin
                     if (slot_begin[i] < lo) lo = slot_begin[i];
                     if (v > hi) hi = v;
                  end
               end
            end
            if (!any) push_rsp(STS_EMPTY, 0, 0, 0, 0, 1);
            else push_rsp(STS_OK, 1, 0, lo, hi, 1);
         end
         default: push_rsp(STS_OK, 0, 0, 0, 0, 1);
      endcase
   endfunction

   // sends one request transfer; entered and left at a rising edge
   task automatic send_item(input logic [2:0] act, input logic [15:0] id, input time_type ws,
                            input time_type we, input bit sl, input bit su);
      if (!no_idle && $urandom_range(0, 99) < IdlePct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      table_predict(act, id, ws, we, sl, su);
      req_tvalid <= 1'b1;
      req_tdata  <= {3'b000, su, sl, we, ws, id, act};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // response side: ready pattern, long hold-off and checking
   always @(posedge clock) begin
      table_rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_rsp.size() == 0) begin
            report_mismatch("unexpected transfer", rsp_tdata[63:0], '0);
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_tdata[2:0] != want.status)
               report_mismatch("status", rsp_tdata[2:0], want.status);
            if (rsp_tdata[3] != want.valid)
               report_mismatch("match_valid", rsp_tdata[3], want.valid);
            if (rsp_tdata[19:4] != want.id)
               report_mismatch("match_id", rsp_tdata[19:4], want.id);
            if (rsp_tdata[83:20] != want.start)
               report_mismatch("match_start", rsp_tdata[83:20], want.start);
            if (rsp_tdata[147:84] != want.stop)
               report_mismatch("match_end", rsp_tdata[147:84], want.stop);
            if (rsp_tlast != want.last)
               report_mismatch("last", rsp_tlast, want.last);
         end
      end
      if (hold_seen != hold_seq) begin
         hold_seen  <= hold_seq;
         hold_left  <= HoldCycles;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= no_idle || ($urandom_range(0, 99) >= IdlePct);
      end
   end

   function automatic time_type rand_time();
      case ($urandom_range(0, 9))
         0: return {$urandom, $urandom};
         1: return $urandom_range(0, 1) ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
         default: return $signed(64'($urandom_range(0, 400))) - 200;
      endcase
   endfunction

   task automatic test_directed();
      time_type tmin;
      time_type tmax;
      tmin = {1'b1, 63'd0};
      tmax = {1'b0, {63{1'b1}}};
      send_item(ACT_SPAN, 0, 0, 0, 0, 0);
      send_item(ACT_REMOVE, 16'h0005, 0, 0, 0, 0);
      send_item(ACT_GET, 16'hffff, 0, 0, 0, 0);
      send_item(ACT_ADD, 16'h0000, tmin, tmax, 0, 0);
      send_item(ACT_ADD, 16'hffff, 10, 20, 1, 1);
      send_item(ACT_ADD, 16'h0000, 1, 2, 0, 0);
      send_item(ACT_ADD, 16'h1234, 30, 29, 0, 0);
      send_item(ACT_ADD, 16'h0042, 15, 40, 0, 0);
      send_item(ACT_ADD, 16'h0043, 10, 25, 0, 0);
      send_item(ACT_GET, 16'hffff, 0, 0, 0, 0);
      send_item(ACT_GET, 16'h0000, 0, 0, 0, 0);
      send_item(ACT_WINDOW, 0, 0, 30, 0, 0);
      send_item(ACT_WINDOW, 0, 0, 30, 0, 1);
      send_item(ACT_WINDOW, 0, 12, 30, 1, 0);
      send_item(ACT_WINDOW, 0, 12, 30, 1, 1);
      send_item(ACT_WINDOW, 0, tmin, tmax, 1, 1);
      send_item(ACT_WINDOW, 0, 30, 12, 0, 0);
      send_item(ACT_WINDOW, 0, 1000, 2000, 0, 0);
      send_item(ACT_SPAN, 0, 0, 0, 0, 0);
      send_item(ACT_SPAN, 0, 0, 0, 0, 1);
      send_item(3'd5, 16'h0042, 1, 2, 1, 1);
      send_item(3'd7, 16'h0042, 1, 2, 0, 0);
      send_item(ACT_REMOVE, 16'h0000, 0, 0, 0, 0);
      send_item(ACT_REMOVE, 16'h0000, 0, 0, 0, 0);
   endtask

   // fill to capacity, check the full answer and full-size queries
   task automatic test_full_table();
      time_type s;
      for (int i = 0; i < Depth + 2; i++) begin
         s = $signed(64'($urandom_range(0, 60)));
         send_item(ACT_ADD, 16'(16'h0100 + i), s, s + $urandom_range(0, 30), 0, 0);
      end
      send_item(ACT_WINDOW, 0, {1'b1, 63'd0}, {1'b0, {63{1'b1}}}, 0, 0);
      send_item(ACT_WINDOW, 0, -5, 50, 1, 1);
      send_item(ACT_SPAN, 0, 0, 0, 0, 1);
      for (int i = 0; i < Depth; i += 2)
         send_item(ACT_REMOVE, 16'(16'h0100 + i), 0, 0, 0, 0);
   endtask

   // long receiver hold-off while the sender keeps offering
   task automatic test_backpressure();
      no_idle = 1;
      hold_seq++;
      for (int i = 0; i < 24; i++)
         send_item(i % 3 == 0 ? ACT_WINDOW : ACT_GET, 16'(16'h0101 + 2 * (i % 8)),
                   -10, 100, 1, 1);
      no_idle = 0;
   endtask

   task automatic test_random();
      logic [2:0]  act;
      logic [15:0] id;
      time_type    ws;
      time_type    we;
      int          pick;
      for (int i = 0; i < 320; i++) begin
         no_idle = (i >= 150 && i < 230);
         pick = $urandom_range(0, 99);
         if (pick < 35) act = ACT_ADD;
         else if (pick < 55) act = ACT_REMOVE;
         else if (pick < 68) act = ACT_GET;
         else if (pick < 88) act = ACT_WINDOW;
         else if (pick < 95) act = ACT_SPAN;
         else act = 3'($urandom_range(5, 7));
         id = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 47));
         ws = rand_time();
         if ($urandom_range(0, 9) == 0) we = rand_time();
         else we = ws + $urandom_range(0, 120);
         send_item(act, id, ws, we, $urandom_range(0, 1), $urandom_range(0, 1));
      end
      no_idle = 0;
   endtask

   // stimulus sequence
   initial begin
      error_count = 0;
      hold_seq    = 0;
      no_idle     = 0;
      next_stamp  = '0;
      for (int i = 0; i < Depth; i++) slot_used[i] = 0;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_full_table();
      test_backpressure();
      test_random();
      req_tvalid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

[filelist.f]
src/twet_pkg.sv
src/twet_ram.sv
src/time_window_entry_table.sv
verif/time_window_entry_table_tb.sv
